### hdl/rgb_color_format_converter_core_assert.svh
// Assertion macros for the RGB color format converter checker.
// Depends on clk_i and rst_ni being visible where the macros are used.
`ifndef RGB_COLOR_FORMAT_CONVERTER_CORE_ASSERT_SVH
`define RGB_COLOR_FORMAT_CONVERTER_CORE_ASSERT_SVH

// Same-cycle implication, clocked on clk_i, off while in reset.
`define RCFC_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> cons) \
    else $error(msg);

// Next-cycle implication, clocked on clk_i, off while in reset.
`define RCFC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> cons) \
    else $error(msg);

`endif

### hdl/rcfc_pkg.sv
// Shared widths, codes, types and helpers for the RGB color format converter.
// No dependencies; every file but the assertion header refers to it by scoped names.
`timescale 1ns / 1ps

package rcfc_pkg;

  localparam int COEF_FRAC_BITS = 16;

  localparam int PIX_W    = 8;
  localparam int WEIGHT_W = 16;
  localparam int CW       = COEF_FRAC_BITS + 2;      // signed Q2.F coefficient
  localparam int PW       = CW + PIX_W + 1;          // coefficient times pixel
  localparam int SW       = COEF_FRAC_BITS + 12;     // channel sum
  localparam int QUO_W    = 2 * COEF_FRAC_BITS + 1;  // divider quotient
  localparam int REM_W    = COEF_FRAC_BITS + 1;      // divider remainder
  localparam int STEP_W   = $clog2(2 * COEF_FRAC_BITS + 1);
  localparam int ONE      = 1 << COEF_FRAC_BITS;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_MODE        = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RED_WEIGHT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BLUE_WEIGHT = 2'd2;

  localparam logic [1:0] MODE_RGB = 2'd0;
  localparam logic [1:0] MODE_BGR = 2'd1;
  localparam logic [1:0] MODE_YCC = 2'd2;

  localparam logic [WEIGHT_W-1:0] RED_WEIGHT_RST  = 16'd19595;
  localparam logic [WEIGHT_W-1:0] BLUE_WEIGHT_RST = 16'd7471;

  typedef logic [COEF_FRAC_BITS-1:0] frac_t;
  typedef logic signed [CW-1:0]      coef_t;

  typedef struct packed {
    frac_t kr;
    frac_t kb;
    coef_t kg;
    coef_t cb_r;
    coef_t cb_g;
    coef_t cr_g;
    coef_t cr_b;
  } mat_t;

  typedef struct packed {
    logic                  we;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] data;
  } cfg_wr_t;

  // Move a Q0.16 weight to Q0.F, truncating when F is below 16.
  function automatic frac_t to_frac(input logic [WEIGHT_W-1:0] w);
    logic [COEF_FRAC_BITS+WEIGHT_W-1:0] wide;
    wide = {{COEF_FRAC_BITS{1'b0}}, w};
    if (COEF_FRAC_BITS >= WEIGHT_W) begin
      wide = wide << (COEF_FRAC_BITS - WEIGHT_W);
    end else begin
      wide = wide >> (WEIGHT_W - COEF_FRAC_BITS);
    end
    return wide[COEF_FRAC_BITS-1:0];
  endfunction

endpackage

### hdl/rcfc_coef_unit.sv
// Weight registers and chroma coefficient generator: one shared restoring
// divider stepped by a small sequencer. Depends on rcfc_pkg.
`timescale 1ns / 1ps

module rcfc_coef_unit (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  rcfc_pkg::cfg_wr_t cfg_i,
  output logic             busy_o,
  output rcfc_pkg::mat_t   mat_o
);

  localparam int F  = rcfc_pkg::COEF_FRAC_BITS;
  localparam int CW = rcfc_pkg::CW;
  localparam int QW = rcfc_pkg::QUO_W;
  localparam int RW = rcfc_pkg::REM_W;
  localparam int TW = rcfc_pkg::STEP_W;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_LOAD = 2'd1;
  localparam logic [1:0] ST_RUN  = 2'd2;

  localparam logic [1:0] SEL_CB_R = 2'd0;
  localparam logic [1:0] SEL_CB_G = 2'd1;
  localparam logic [1:0] SEL_CR_G = 2'd2;
  localparam logic [1:0] SEL_CR_B = 2'd3;

  localparam logic [CW-1:0] COEF_MAX = {1'b0, {(CW-1){1'b1}}};
  localparam logic [CW-1:0] COEF_MIN = {1'b1, {(CW-1){1'b0}}};

  logic [rcfc_pkg::WEIGHT_W-1:0] red_weight_q, blue_weight_q;
  logic [1:0]    state_q, state_d;
  logic [1:0]    sel_q, sel_d;
  logic [TW-1:0] step_q, step_d;
  logic [RW-1:0] rem_q, rem_d;
  logic [RW-1:0] dvd_q, dvd_d;
  logic [QW-1:0] quo_q, quo_d;
  rcfc_pkg::coef_t cb_r_q, cb_g_q, cr_g_q, cr_b_q;
  rcfc_pkg::frac_t kr_q, kb_q;
  rcfc_pkg::coef_t kg_q;

  rcfc_pkg::frac_t kr, kb, k_sel;
  logic [CW-1:0]   kg;
  logic            w_neg;
  logic [RW-1:0]   w_mag;
  logic [CW-1:0]   den;
  logic [CW-1:0]   trial;
  logic            qbit;
  logic            weight_wr;
  logic            coef_we;
  logic [CW-1:0]   quo_lo;
  rcfc_pkg::coef_t coef_new;

  assign kr = rcfc_pkg::to_frac(red_weight_q);
  assign kb = rcfc_pkg::to_frac(blue_weight_q);
  assign kg = CW'(rcfc_pkg::ONE) - CW'(kr) - CW'(kb);

  assign weight_wr = cfg_i.we && ((cfg_i.idx == rcfc_pkg::CFG_RED_WEIGHT) ||
                                  (cfg_i.idx == rcfc_pkg::CFG_BLUE_WEIGHT));

  // Numerator weight and luma weight of the divisor for the current coefficient.
  always_comb begin
    unique case (sel_q)
      SEL_CB_R: begin
        w_neg = 1'b0;
        w_mag = RW'(kr);
        k_sel = kb;
      end
      SEL_CB_G: begin
        w_neg = kg[CW-1];
        w_mag = kg[CW-1] ? RW'(-kg) : RW'(kg);
        k_sel = kb;
      end
      SEL_CR_G: begin
        w_neg = kg[CW-1];
        w_mag = kg[CW-1] ? RW'(-kg) : RW'(kg);
        k_sel = kr;
      end
      default: begin
        w_neg = 1'b0;
        w_mag = RW'(kb);
        k_sel = kr;
      end
    endcase
  end

  assign den   = CW'((CW'(rcfc_pkg::ONE) - CW'(k_sel)) << 1);
  assign trial = {rem_q, dvd_q[RW-1]};
  assign qbit  = (trial >= den);

  always_comb begin
    state_d = state_q;
    sel_d   = sel_q;
    step_d  = step_q;
    rem_d   = rem_q;
    dvd_d   = dvd_q;
    quo_d   = quo_q;
    coef_we = 1'b0;
    if (weight_wr) begin
      // restart the whole coefficient set on any weight change
      state_d = ST_LOAD;
      sel_d   = SEL_CB_R;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          state_d = ST_IDLE;
        end
        ST_LOAD: begin
          rem_d   = '0;
          dvd_d   = w_mag;
          quo_d   = '0;
          step_d  = '0;
          state_d = ST_RUN;
        end
        ST_RUN: begin
          rem_d  = qbit ? RW'(trial - den) : RW'(trial);
          dvd_d  = dvd_q << 1;
          quo_d  = {quo_q[QW-2:0], qbit};
          step_d = step_q + 1'b1;
          if (step_q == TW'(2 * F)) begin
            coef_we = 1'b1;
            if (sel_q == SEL_CR_B) begin
              state_d = ST_IDLE;
            end else begin
              sel_d   = sel_q + 1'b1;
              state_d = ST_LOAD;
            end
          end
        end
        default: begin
          state_d = ST_IDLE;
        end
      endcase
    end
  end

  // Give the finished quotient the sign opposite the weight and saturate it to the Q2.F range.
  assign quo_lo = quo_d[CW-1:0];
  always_comb begin
    if (!w_neg) begin
      if (quo_d > QW'(COEF_MIN)) begin
        coef_new = $signed(COEF_MIN);
      end else begin
        coef_new = $signed(CW'(-quo_lo));
      end
    end else begin
      if (quo_d > QW'(COEF_MAX)) begin
        coef_new = $signed(COEF_MAX);
      end else begin
        coef_new = $signed(quo_lo);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      red_weight_q  <= rcfc_pkg::RED_WEIGHT_RST;
      blue_weight_q <= rcfc_pkg::BLUE_WEIGHT_RST;
      state_q       <= ST_LOAD;
      sel_q         <= SEL_CB_R;
      step_q        <= '0;
    end else begin
      if (cfg_i.we && (cfg_i.idx == rcfc_pkg::CFG_RED_WEIGHT)) begin
        red_weight_q <= cfg_i.data[rcfc_pkg::WEIGHT_W-1:0];
      end
      if (cfg_i.we && (cfg_i.idx == rcfc_pkg::CFG_BLUE_WEIGHT)) begin
        blue_weight_q <= cfg_i.data[rcfc_pkg::WEIGHT_W-1:0];
      end
      state_q <= state_d;
      sel_q   <= sel_d;
      step_q  <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvd_q <= dvd_d;
    quo_q <= quo_d;
    kr_q  <= kr;
    kb_q  <= kb;
    kg_q  <= $signed(kg);
    if (coef_we) begin
      unique case (sel_q)
        SEL_CB_R: cb_r_q <= coef_new;
        SEL_CB_G: cb_g_q <= coef_new;
        SEL_CR_G: cr_g_q <= coef_new;
        default:  cr_b_q <= coef_new;
      endcase
    end
  end

  assign busy_o     = (state_q != ST_IDLE);
  assign mat_o.kr   = kr_q;
  assign mat_o.kb   = kb_q;
  assign mat_o.kg   = kg_q;
  assign mat_o.cb_r = cb_r_q;
  assign mat_o.cb_g = cb_g_q;
  assign mat_o.cr_g = cr_g_q;
  assign mat_o.cr_b = cr_b_q;

endmodule

### hdl/rcfc_pipe.sv
// Four-stage pixel datapath: capture, products, channel sums, clamp and
// mode select. Depends on rcfc_pkg.
`timescale 1ns / 1ps

module rcfc_pipe (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       valid_i,
  input  logic [1:0]                 mode_i,
  input  logic [rcfc_pkg::PIX_W-1:0] red_i,
  input  logic [rcfc_pkg::PIX_W-1:0] green_i,
  input  logic [rcfc_pkg::PIX_W-1:0] blue_i,
  input  rcfc_pkg::mat_t             mat_i,
  output logic                       valid_o,
  output logic [rcfc_pkg::PIX_W-1:0] chan0_o,
  output logic [rcfc_pkg::PIX_W-1:0] chan1_o,
  output logic [rcfc_pkg::PIX_W-1:0] chan2_o
);

  localparam int F  = rcfc_pkg::COEF_FRAC_BITS;
  localparam int XW = rcfc_pkg::PIX_W;
  localparam int PW = rcfc_pkg::PW;
  localparam int SW = rcfc_pkg::SW;
  localparam int VW = SW - 1 - F;

  // Drop negative sums to zero, truncate the fraction, clamp to full scale.
  function automatic logic [XW-1:0] finish(input logic signed [SW-1:0] sum);
    logic [VW-1:0] v;
    v = sum[SW-2:F];
    if (sum[SW-1]) begin
      return '0;
    end else if (v > VW'({XW{1'b1}})) begin
      return {XW{1'b1}};
    end else begin
      return v[XW-1:0];
    end
  endfunction

  // stage 1: capture
  logic          v1_q;
  logic [1:0]    m1_q;
  logic [XW-1:0] r1_q, g1_q, b1_q;

  // stage 2: products
  logic          v2_q;
  logic [1:0]    m2_q;
  logic [XW-1:0] r2_q, g2_q, b2_q;
  logic signed [PW-1:0] py_r_q, py_g_q, py_b_q, pcb_r_q, pcb_g_q, pcr_g_q, pcr_b_q;

  // stage 3: sums
  logic          v3_q;
  logic [1:0]    m3_q;
  logic [XW-1:0] r3_q, g3_q, b3_q;
  logic signed [SW-1:0] sy_q, scb_q, scr_q;
  logic signed [SW-1:0] half_r, half_b, ofs;

  // stage 4: output
  logic          v4_q;
  logic [XW-1:0] c0_q, c1_q, c2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    m1_q <= mode_i;
    r1_q <= red_i;
    g1_q <= green_i;
    b1_q <= blue_i;
  end

  always_ff @(posedge clk_i) begin
    m2_q    <= m1_q;
    r2_q    <= r1_q;
    g2_q    <= g1_q;
    b2_q    <= b1_q;
    py_r_q  <= PW'($signed({2'b00, mat_i.kr})) * PW'($signed({1'b0, r1_q}));
    py_g_q  <= PW'($signed(mat_i.kg)) * PW'($signed({1'b0, g1_q}));
    py_b_q  <= PW'($signed({2'b00, mat_i.kb})) * PW'($signed({1'b0, b1_q}));
    pcb_r_q <= PW'($signed(mat_i.cb_r)) * PW'($signed({1'b0, r1_q}));
    pcb_g_q <= PW'($signed(mat_i.cb_g)) * PW'($signed({1'b0, g1_q}));
    pcr_g_q <= PW'($signed(mat_i.cr_g)) * PW'($signed({1'b0, g1_q}));
    pcr_b_q <= PW'($signed(mat_i.cr_b)) * PW'($signed({1'b0, b1_q}));
  end

  // 1/2 coefficient is a shift; chroma offset is 128 in Q.F
  assign half_r = $signed(SW'(r2_q) << (F - 1));
  assign half_b = $signed(SW'(b2_q) << (F - 1));
  assign ofs    = $signed(SW'(128) << F);

  always_ff @(posedge clk_i) begin
    m3_q  <= m2_q;
    r3_q  <= r2_q;
    g3_q  <= g2_q;
    b3_q  <= b2_q;
    sy_q  <= SW'(py_r_q) + SW'(py_g_q) + SW'(py_b_q);
    scb_q <= SW'(pcb_r_q) + SW'(pcb_g_q) + half_b + ofs;
    scr_q <= half_r + SW'(pcr_g_q) + SW'(pcr_b_q) + ofs;
  end

  always_ff @(posedge clk_i) begin
    unique case (m3_q)
      rcfc_pkg::MODE_BGR: begin
        c0_q <= b3_q;
        c1_q <= g3_q;
        c2_q <= r3_q;
      end
      rcfc_pkg::MODE_YCC: begin
        c0_q <= finish(sy_q);
        c1_q <= finish(scb_q);
        c2_q <= finish(scr_q);
      end
      default: begin
        // passthrough, unused mode code included
        c0_q <= r3_q;
        c1_q <= g3_q;
        c2_q <= b3_q;
      end
    endcase
  end

  assign valid_o = v4_q;
  assign chan0_o = c0_q;
  assign chan1_o = c1_q;
  assign chan2_o = c2_q;

endmodule

### hdl/rgb_color_format_converter_core.sv
// Top level of the RGB color format converter: mode register, coefficient
// unit and pixel pipeline. Depends on rcfc_pkg, rcfc_coef_unit, rcfc_pipe.
`timescale 1ns / 1ps

// Usage:
//   Input: drive red_i, green_i, blue_i with start_i high; the word is taken
//   at a rising edge where start_i is high and busy_o is low.
//   Output: done_o is high for one cycle with chan0_o..chan2_o valid; the
//   word counts as taken at the edge ending that cycle. There is no
//   backpressure, so the pipeline never stalls.
//   Throughput: one word per cycle while busy_o is low.
//   Pipeline: a taken word passes four register stages (capture, multiply,
//   sum, clamp/select) and then shows done_o.
//   Configuration: cfg_we_i with cfg_idx_i 0 (mode), 1 (red weight) or
//   2 (blue weight) and cfg_wdata_i; other indexes are ignored. Write only
//   when no word is in flight.
//   busy_o: after reset and after every weight write, the chroma
//   coefficients are rebuilt by one shared restoring divider, one quotient
//   bit per cycle. A mode write does not raise busy_o.
//   Reset: mode clears to passthrough, weights load their defaults, no
//   result is pending.

module rgb_color_format_converter_core (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  output logic                            busy_o,
  input  logic [rcfc_pkg::PIX_W-1:0]      red_i,
  input  logic [rcfc_pkg::PIX_W-1:0]      green_i,
  input  logic [rcfc_pkg::PIX_W-1:0]      blue_i,
  input  logic                            cfg_we_i,
  input  logic [rcfc_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [rcfc_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  output logic                            done_o,
  output logic [rcfc_pkg::PIX_W-1:0]      chan0_o,
  output logic [rcfc_pkg::PIX_W-1:0]      chan1_o,
  output logic [rcfc_pkg::PIX_W-1:0]      chan2_o
);

  rcfc_pkg::cfg_wr_t cfg;
  rcfc_pkg::mat_t    mat;
  logic [1:0]        mode_q;
  logic              busy;
  logic              accept;

  assign cfg.we   = cfg_we_i;
  assign cfg.idx  = cfg_idx_i;
  assign cfg.data = cfg_wdata_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= rcfc_pkg::MODE_RGB;
    end else if (cfg_we_i && (cfg_idx_i == rcfc_pkg::CFG_MODE)) begin
      mode_q <= cfg_wdata_i[1:0];
    end
  end

  assign accept = start_i && !busy;

  rcfc_coef_unit u_coef (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .busy_o (busy),
    .mat_o  (mat)
  );

  rcfc_pipe u_pipe (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (accept),
    .mode_i  (mode_q),
    .red_i   (red_i),
    .green_i (green_i),
    .blue_i  (blue_i),
    .mat_i   (mat),
    .valid_o (done_o),
    .chan0_o (chan0_o),
    .chan1_o (chan1_o),
    .chan2_o (chan2_o)
  );

  assign busy_o = busy;

endmodule

### hdl/rcfc_checker.sv
// Port-level checker for the RGB color format converter, bound to the top.
// Depends on rcfc_pkg and rgb_color_format_converter_core_assert.svh.
`timescale 1ns / 1ps
`include "rgb_color_format_converter_core_assert.svh"

module rcfc_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           start_i,
  input logic                           busy_o,
  input logic                           done_o,
  input logic                           cfg_we_i,
  input logic [rcfc_pkg::CFG_IDX_W-1:0] cfg_idx_i
);

  logic taken;
  logic weight_wr;
  logic mode_wr;

  assign taken     = start_i && !busy_o;
  assign weight_wr = cfg_we_i && ((cfg_idx_i == rcfc_pkg::CFG_RED_WEIGHT) ||
                                  (cfg_idx_i == rcfc_pkg::CFG_BLUE_WEIGHT));
  assign mode_wr   = cfg_we_i && (cfg_idx_i == rcfc_pkg::CFG_MODE);

  // every taken word comes out on done_o
  `RCFC_ASSERT_SAME(a_word_out, taken, ##4 done_o, "taken word not delivered")

  // no result without a word taken before it
  `RCFC_ASSERT_SAME(a_no_phantom, done_o, ($past(taken, 4)), "result without a word")

  // a weight write must rebuild the coefficients
  `RCFC_ASSERT_NEXT(a_weight_busy, weight_wr, busy_o, "weight write did not raise busy")

  // a mode write leaves an idle block idle
  `RCFC_ASSERT_NEXT(a_mode_idle, mode_wr && !busy_o, !busy_o, "mode write raised busy")

endmodule

bind rgb_color_format_converter_core rcfc_checker u_checker (.*);

### sim/rgb_color_format_converter_core_tb.sv
// Self-checking testbench for rgb_color_format_converter_core: directed and
// random colors over all modes and over directed and random weight settings. Depends on rcfc_pkg.
`timescale 1ns / 1ps

module rgb_color_format_converter_core_tb;

  localparam int FRAC       = rcfc_pkg::COEF_FRAC_BITS;
  localparam int PIX_W      = rcfc_pkg::PIX_W;
  localparam int WEIGHT_W   = rcfc_pkg::WEIGHT_W;
  localparam int CFG_IDX_W  = rcfc_pkg::CFG_IDX_W;
  localparam int CFG_DATA_W = rcfc_pkg::CFG_DATA_W;
  localparam int LATENCY  = 4;
  localparam int RANDOM_WORDS = 1830;
  localparam int MAX_SHOWN    = 10;

  // Codes the package leaves unnamed: the spare register index and mode.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE  = 2'd3;
  localparam logic [1:0]           MODE_SPARE = 2'd3;

  typedef struct packed {
    logic [PIX_W-1:0] c0;
    logic [PIX_W-1:0] c1;
    logic [PIX_W-1:0] c2;
  } colour_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  start_i;
  logic                  busy_o;
  logic [PIX_W-1:0]      red_i;
  logic [PIX_W-1:0]      green_i;
  logic [PIX_W-1:0]      blue_i;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;
  logic                  done_o;
  logic [PIX_W-1:0]      chan0_o;
  logic [PIX_W-1:0]      chan1_o;
  logic [PIX_W-1:0]      chan2_o;

  // Shadow copy of the block's registers.
  logic [1:0]            cur_mode;
  logic [WEIGHT_W-1:0]   cur_kr;
  logic [WEIGHT_W-1:0]   cur_kb;

  colour_t expected_colours[$];
  int      words_sent;
  int      results_seen;
  int      reg_writes;
  int      settings_run;
  int      mismatches;

  rgb_color_format_converter_core DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .busy_o      (busy_o),
    .red_i       (red_i),
    .green_i     (green_i),
    .blue_i      (blue_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .done_o      (done_o),
    .chan0_o     (chan0_o),
    .chan1_o     (chan1_o),
    .chan2_o     (chan2_o)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // ---------------------------------------------------------------------
  // Color conversion predictor
  // ---------------------------------------------------------------------

  function automatic longint weight_to_frac(input logic [WEIGHT_W-1:0] w);
    longint v;
    v = longint'(w);
    if (FRAC >= WEIGHT_W) begin
      return v <<< (FRAC - WEIGHT_W);
    end else begin
      return v >>> (WEIGHT_W - FRAC);
    end
  endfunction

  // -(w * one) / (2 * (one - k)), truncated toward zero, held to signed Q2.F.
  function automatic longint chroma_weight(input longint w, input longint k);
    longint unit;
    longint lim;
    longint den;
    longint q;
    unit = longint'(1) <<< FRAC;
    lim  = longint'(1) <<< (FRAC + 1);
    den  = 2 * (unit - k);
    if (den <= 0) begin
      den = 1;
    end
    q = -((w * unit) / den);
    if (q < -lim) begin
      q = -lim;
    end
    if (q > lim - 1) begin
      q = lim - 1;
    end
    return q;
  endfunction

  function automatic logic [PIX_W-1:0] clamp_channel(input longint sum);
    longint v;
    if (sum < 0) begin
      return '0;
    end
    v = sum >>> FRAC;
    return (v > 255) ? 8'd255 : v[PIX_W-1:0];
  endfunction

  function automatic colour_t convert_colour(input logic [PIX_W-1:0] r,
                                             input logic [PIX_W-1:0] g,
                                             input logic [PIX_W-1:0] b);
    colour_t c;
    longint  unit;
    longint  kr;
    longint  kb;
    longint  kg;
    longint  ri;
    longint  gi;
    longint  bi;
    longint  offset;
    unit   = longint'(1) <<< FRAC;
    kr     = weight_to_frac(cur_kr);
    kb     = weight_to_frac(cur_kb);
    kg     = unit - kr - kb;
    ri     = longint'(r);
    gi     = longint'(g);
    bi     = longint'(b);
    offset = 128 * unit;
    case (cur_mode)
      rcfc_pkg::MODE_BGR: begin
        c = '{c0: b, c1: g, c2: r};
      end
      rcfc_pkg::MODE_YCC: begin
        c.c0 = clamp_channel(kr * ri + kg * gi + kb * bi);
        c.c1 = clamp_channel(chroma_weight(kr, kb) * ri + chroma_weight(kg, kb) * gi
                             + (unit / 2) * bi + offset);
        c.c2 = clamp_channel((unit / 2) * ri + chroma_weight(kg, kr) * gi
                             + chroma_weight(kb, kr) * bi + offset);
      end
      default: begin
        c = '{c0: r, c1: g, c2: b};
      end
    endcase
    return c;
  endfunction

  // ---------------------------------------------------------------------
  // Driving
  // ---------------------------------------------------------------------

  task automatic send_colour(input logic [PIX_W-1:0] r, input logic [PIX_W-1:0] g,
                             input logic [PIX_W-1:0] b);
    @(negedge clk_i);
    start_i = 1'b1;
    red_i   = r;
    green_i = g;
    blue_i  = b;
    do @(posedge clk_i); while (busy_o);
    expected_colours.push_back(convert_colour(r, g, b));
    words_sent++;
  endtask

  task automatic idle_cycles(input int n);
    repeat (n) begin
      @(negedge clk_i);
      start_i = 1'b0;
      red_i   = PIX_W'($urandom());
      green_i = PIX_W'($urandom());
      blue_i  = PIX_W'($urandom());
    end
  endtask

  // Drop start, then let every word in flight come out before touching
  // the registers.
  task automatic drain_pipeline();
    @(negedge clk_i);
    start_i = 1'b0;
    while (expected_colours.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 2) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    start_i     = 1'b0;
    cfg_we_i    = 1'b1;
    cfg_idx_i   = idx;
    cfg_wdata_i = data;
    @(negedge clk_i);
    cfg_we_i    = 1'b0;
    cfg_wdata_i = CFG_DATA_W'($urandom());
    case (idx)
      rcfc_pkg::CFG_MODE:        cur_mode = data[1:0];
      rcfc_pkg::CFG_RED_WEIGHT:  cur_kr   = data;
      rcfc_pkg::CFG_BLUE_WEIGHT: cur_kb   = data;
      default: ;
    endcase
    reg_writes++;
    // Hold until the coefficient rebuild is over.
    repeat (2) @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
  endtask

  task automatic set_mode(input logic [1:0] m);
    logic [CFG_DATA_W-1:0] data;
    data      = CFG_DATA_W'($urandom());
    data[1:0] = m;
    write_reg(rcfc_pkg::CFG_MODE, data);
  endtask

  task automatic set_weights(input logic [WEIGHT_W-1:0] kr,
                             input logic [WEIGHT_W-1:0] kb);
    write_reg(rcfc_pkg::CFG_RED_WEIGHT, kr);
    write_reg(rcfc_pkg::CFG_BLUE_WEIGHT, kb);
    settings_run++;
  endtask

  task automatic send_primaries();
    send_colour(8'hFF, 8'hFF, 8'hFF);
    send_colour(8'h00, 8'h00, 8'h00);
    send_colour(8'hFF, 8'h00, 8'h80);
  endtask

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------

  task automatic test_reset_passthrough();
    send_colour(8'h00, 8'h00, 8'h00);
    send_colour(8'hFF, 8'hFF, 8'hFF);
    send_colour(8'hAA, 8'h55, 8'h0F);
    drain_pipeline();
  endtask

  task automatic test_swap_and_spare_mode();
    set_mode(rcfc_pkg::MODE_BGR);
    send_colour(8'h01, 8'h80, 8'hFE);
    send_colour(8'hF0, 8'h3C, 8'h0F);
    drain_pipeline();
    set_mode(MODE_SPARE);
    send_colour(8'h01, 8'h80, 8'hFE);
    send_colour(8'h55, 8'hAA, 8'h33);
    drain_pipeline();
  endtask

  task automatic test_ycc_reset_weights();
    set_mode(rcfc_pkg::MODE_YCC);
    send_primaries();
    send_colour(8'h00, 8'hFF, 8'h00);
    drain_pipeline();
  endtask

  // Zero weights, weights summing past one (negative green weight and
  // saturated chroma coefficients), and all weight on red.
  task automatic test_ycc_weight_extremes();
    set_weights(16'd0, 16'd0);
    send_primaries();
    drain_pipeline();
    set_weights(16'hFFFF, 16'hFFFF);
    send_primaries();
    drain_pipeline();
    set_weights(16'hFFFF, 16'd0);
    send_primaries();
    drain_pipeline();
  endtask

  // A write to the spare index must leave mode and weights untouched.
  task automatic test_spare_index();
    write_reg(CFG_SPARE, 16'hFFFF);
    send_colour(8'h7F, 8'h80, 8'hC3);
    drain_pipeline();
  endtask

  task automatic run_traffic(input int n);
    int left;
    int burst;
    left = n;
    while (left > 0) begin
      burst = $urandom_range(1, 40);
      if (burst > left) begin
        burst = left;
      end
      repeat (burst) begin
        send_colour(PIX_W'($urandom()), PIX_W'($urandom()), PIX_W'($urandom()));
      end
      left -= burst;
      if ($urandom_range(0, 3) != 0) begin
        idle_cycles($urandom_range(1, 10));
      end
    end
  endtask

  task automatic test_random_settings();
    int                    done_words;
    int                    phase_words;
    logic [WEIGHT_W-1:0]   kr;
    logic [WEIGHT_W-1:0]   kb;
    done_words = 0;
    while (done_words < RANDOM_WORDS) begin
      case ($urandom_range(0, 3))
        0: begin
          kr = ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'd0;
          kb = ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'd1;
        end
        1: begin
          kr = WEIGHT_W'($urandom());
          kb = WEIGHT_W'($urandom());
        end
        default: begin
          // Realistic weights: Kr plus Kb below one.
          kr = WEIGHT_W'($urandom_range(0, 40000));
          kb = WEIGHT_W'($urandom_range(0, 65535 - kr - 1));
        end
      endcase
      set_weights(kr, kb);
      set_mode(($urandom_range(0, 2) != 0) ? rcfc_pkg::MODE_YCC
                                           : 2'($urandom_range(0, 3)));
      phase_words = $urandom_range(60, 200);
      if (phase_words > RANDOM_WORDS - done_words) begin
        phase_words = RANDOM_WORDS - done_words;
      end
      run_traffic(phase_words);
      done_words += phase_words;
      drain_pipeline();
    end
  endtask

  // ---------------------------------------------------------------------
  // Result checking
  // ---------------------------------------------------------------------

  always @(posedge clk_i) begin
    colour_t want;
    if (rst_ni && done_o) begin
      results_seen++;
      if (expected_colours.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_SHOWN) begin
          $display("%0t: unexpected word %h %h %h", $realtime, chan0_o, chan1_o, chan2_o);
        end
      end else begin
        want = expected_colours.pop_front();
        if (chan0_o !== want.c0 || chan1_o !== want.c1 || chan2_o !== want.c2) begin
          mismatches++;
          if (mismatches <= MAX_SHOWN) begin
            $display("%0t: mode %0d kr %0d kb %0d: expected %h %h %h, got %h %h %h",
                     $realtime, cur_mode, cur_kr, cur_kb, want.c0, want.c1, want.c2,
                     chan0_o, chan1_o, chan2_o);
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------

  initial begin
    int leftover;
    rst_ni       = 1'b0;
    start_i      = 1'b0;
    red_i        = '0;
    green_i      = '0;
    blue_i       = '0;
    cfg_we_i     = 1'b0;
    cfg_idx_i    = rcfc_pkg::CFG_MODE;
    cfg_wdata_i  = '0;
    cur_mode     = rcfc_pkg::MODE_RGB;
    cur_kr       = rcfc_pkg::RED_WEIGHT_RST;
    cur_kb       = rcfc_pkg::BLUE_WEIGHT_RST;
    words_sent   = 0;
    results_seen = 0;
    reg_writes   = 0;
    settings_run = 1;
    mismatches   = 0;
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;

    test_reset_passthrough();
    test_swap_and_spare_mode();
    test_ycc_reset_weights();
    test_ycc_weight_extremes();
    test_spare_index();
    test_random_settings();

    drain_pipeline();
    leftover = expected_colours.size();
    $display("Sent %0d words over %0d weight settings with %0d register writes;",
             words_sent, settings_run, reg_writes);
    $display("checked %0d results, %0d mismatches, %0d missing.",
             results_seen, mismatches, leftover);
    if (mismatches == 0 && leftover == 0) begin
      $display("rgb_color_format_converter_core_tb OK");
    end else begin
      $display("rgb_color_format_converter_core_tb NOT OK");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Timeout with %0d results still pending", expected_colours.size());
    $display("rgb_color_format_converter_core_tb NOT OK");
    $finish;
  end

endmodule
